/* rtl/core/agpm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agpm_pkg
// Shared types, constants and control word layout for the PCM mixer.
// ----------------------------------------------------------------------------
package agpm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int REG_IDX_W  = 4;
  localparam int STEP_W     = 4;
  localparam int SUM_W      = 34;   // exact Q.12 sum of two 16x16 products
  localparam int PROD_W     = 51;   // 34-bit sum times 17-bit factor
  localparam int SCALED_W   = 24;   // sample after the Q1.15 / Q4.12 shift
  localparam int PROD_SHIFT = 27;
  localparam int QUO_W      = 15;   // new factor is always below 1.0
  localparam int NUM_W      = 31;
  localparam int RECOVERY_SHIFT = 5;

  localparam logic [GAIN_W-1:0]   GAIN_RESET = 16'd4096;
  localparam logic [15:0]         UNITY_Q15  = 16'h8000;
  localparam logic [NUM_W-1:0]    NUM_POS    = 31'd32767 * 31'd32768;
  localparam logic [NUM_W-1:0]    NUM_NEG    = 31'd32768 * 31'd32768;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  localparam logic [REG_IDX_W-1:0] REG_MUSIC_GAIN = 4'd0;
  localparam logic [REG_IDX_W-1:0] REG_VOCAL_GAIN = 4'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] vocal_sample;
    logic signed [SAMPLE_W-1:0] music_sample;
    logic                       in_last;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic                       clipped;
    logic                       out_last;
  } result_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] reg_index;
    logic [GAIN_W-1:0]    wdata;
  } cfg_write_t;

  typedef enum logic [1:0] {
    MUL_MUSIC = 2'd0,
    MUL_VOCAL = 2'd1,
    MUL_SUM   = 2'd2
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef enum logic [2:0] {
    JMP_NONE     = 3'd0,
    JMP_NO_INPUT = 3'd1,
    JMP_NO_CLIP  = 3'd2,
    JMP_DIV_MORE = 3'd3,
    JMP_OUT_BUSY = 3'd4,
    JMP_ALWAYS   = 3'd5
  } jmp_t;

  // program step addresses
  localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_M   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_V   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_ADD     = 4'd3;
  localparam logic [STEP_W-1:0] STEP_MUL_A   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SCALE   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_CHECK   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DIV     = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DIV_END = 4'd8;
  localparam logic [STEP_W-1:0] STEP_RECOVER = 4'd9;
  localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd10;
  localparam logic [STEP_W-1:0] STEP_WRAP    = 4'd11;

  typedef struct packed {
    logic              accept;
    logic              mul_en;
    mul_sel_t          mul_sel;
    acc_op_t           acc_op;
    logic              scale_en;
    logic              div_init;
    logic              div_step;
    logic              att_load;
    logic              recover;
    logic              emit;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic no_clip;
    logic div_more;
    logic out_busy;
  } stat_t;

endpackage

/* rtl/core/agpm_chan_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agpm_chan_if
// Valid/ready channel carrying one payload item of type T.
// ----------------------------------------------------------------------------
interface agpm_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/agpm_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agpm_seq
// Step counter and control store; one control word per step, with
// conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module agpm_seq (
  input  logic          clk,
  input  logic          rst,
  input  agpm_pkg::stat_t stat,
  output agpm_pkg::ctl_t  ctl
);
  import agpm_pkg::*;

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  logic              taken;

  function automatic ctl_t rom_word(input logic [STEP_W-1:0] step);
    ctl_t w;
    w = '{accept: 1'b0, mul_en: 1'b0, mul_sel: MUL_MUSIC, acc_op: ACC_HOLD,
          scale_en: 1'b0, div_init: 1'b0, div_step: 1'b0, att_load: 1'b0,
          recover: 1'b0, emit: 1'b0, jmp: JMP_NONE, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        w.accept = 1'b1;
        w.jmp    = JMP_NO_INPUT;
        w.target = STEP_IDLE;
      end
      STEP_MUL_M: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_MUSIC;
      end
      STEP_MUL_V: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_VOCAL;
        w.acc_op  = ACC_LOAD;
      end
      STEP_ADD: begin
        w.acc_op = ACC_ADD;
      end
      STEP_MUL_A: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_SUM;
      end
      STEP_SCALE: begin
        w.scale_en = 1'b1;
      end
      STEP_CHECK: begin
        w.div_init = 1'b1;
        w.jmp      = JMP_NO_CLIP;
        w.target   = STEP_RECOVER;
      end
      STEP_DIV: begin
        w.div_step = 1'b1;
        w.jmp      = JMP_DIV_MORE;
        w.target   = STEP_DIV;
      end
      STEP_DIV_END: begin
        w.att_load = 1'b1;
      end
      STEP_RECOVER: begin
        w.recover = 1'b1;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.jmp    = JMP_OUT_BUSY;
        w.target = STEP_EMIT;
      end
      STEP_WRAP: begin
        w.jmp    = JMP_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jmp    = JMP_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  always_comb begin
    ctl = rom_word(pc);
  end

  always_comb begin
    case (ctl.jmp)
      JMP_NONE:     taken = 1'b0;
      JMP_NO_INPUT: taken = ~stat.in_valid;
      JMP_NO_CLIP:  taken = stat.no_clip;
      JMP_DIV_MORE: taken = stat.div_more;
      JMP_OUT_BUSY: taken = stat.out_busy;
      JMP_ALWAYS:   taken = 1'b1;
      default:      taken = 1'b0;
    endcase
    pc_next = taken ? ctl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    pc <= STEP_WRAP)
    else $error("step counter left the program");

  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_EMIT && stat.out_busy) |=> pc == STEP_EMIT)
    else $error("emit step left while output still held");
`endif

endmodule

/* rtl/core/agpm_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agpm_dp
// Mixer datapath: shared multiplier, accumulator, scaler, limiter,
// radix-2 restoring divider, factor register and output register.
// ----------------------------------------------------------------------------
module agpm_dp (
  input  logic            clk,
  input  logic            rst,
  input  agpm_pkg::ctl_t  ctl,
  output agpm_pkg::stat_t stat,
  agpm_chan_if.sink       sample,
  agpm_chan_if.source     result,
  agpm_chan_if.sink       cfg
);
  import agpm_pkg::*;

  // configuration
  logic [GAIN_W-1:0] music_gain;
  logic [GAIN_W-1:0] vocal_gain;

  // item registers
  logic signed [SAMPLE_W-1:0] vocal;
  logic signed [SAMPLE_W-1:0] music;
  logic                       last;

  logic signed [SUM_W-1:0]    mul_a;
  logic signed [GAIN_W:0]     mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SUM_W-1:0]    acc;
  logic signed [PROD_W-1:0]   scaled;
  logic signed [SCALED_W-1:0] level;
  logic                       clip_pos;
  logic                       clip_neg;

  // divider
  logic [SCALED_W-1:0]   divisor;
  logic [SCALED_W-1:0]   rem;
  logic [QUO_W-1:0]      dq;
  logic [3:0]            div_cnt;
  logic [NUM_W-1:0]      numer;
  logic [SCALED_W:0]     trial;
  logic [SCALED_W:0]     diff;
  logic                  fits;

  logic [15:0]           attenuation;
  logic [15:0]           headroom;

  logic signed [SAMPLE_W-1:0] mixed;
  logic                       clip;
  logic                       out_valid;
  result_t                    out_data;

  logic accept_fire;
  logic emit_fire;
  logic out_busy;

  assign sample.ready = ctl.accept;
  assign accept_fire  = sample.valid & ctl.accept;
  assign cfg.ready    = 1'b1;

  assign out_busy     = out_valid & ~result.ready;
  assign emit_fire    = ctl.emit & ~out_busy;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  always_comb begin
    case (ctl.mul_sel)
      MUL_MUSIC: begin
        mul_a = {{(SUM_W-SAMPLE_W){music[SAMPLE_W-1]}}, music};
        mul_b = {1'b0, music_gain};
      end
      MUL_VOCAL: begin
        mul_a = {{(SUM_W-SAMPLE_W){vocal[SAMPLE_W-1]}}, vocal};
        mul_b = {1'b0, vocal_gain};
      end
      MUL_SUM: begin
        mul_a = acc;
        mul_b = {1'b0, attenuation};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // truncate toward zero: bias negative values before the arithmetic shift
  always_comb begin
    scaled = prod + (prod[PROD_W-1] ? PROD_W'((64'd1 << PROD_SHIFT) - 64'd1) : '0);
  end

  assign clip_pos = level > SCALED_W'(32'sd32767);
  assign clip_neg = level < -SCALED_W'(32'sd32768);
  assign numer    = clip_pos ? NUM_POS : NUM_NEG;

  assign trial = {rem, dq[QUO_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  assign headroom = UNITY_Q15 - attenuation;

  assign stat.in_valid = sample.valid;
  assign stat.no_clip  = ~(clip_pos | clip_neg);
  assign stat.div_more = div_cnt != 4'd1;
  assign stat.out_busy = out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      music_gain <= GAIN_RESET;
      vocal_gain <= GAIN_RESET;
    end else if (cfg.valid) begin
      if (cfg.data.reg_index == REG_MUSIC_GAIN) begin
        music_gain <= cfg.data.wdata;
      end else if (cfg.data.reg_index == REG_VOCAL_GAIN) begin
        vocal_gain <= cfg.data.wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_fire) begin
      vocal <= sample.data.vocal_sample;
      music <= sample.data.music_sample;
      last  <= sample.data.in_last;
    end
    if (ctl.mul_en) begin
      prod <= mul_a * mul_b;
    end
    case (ctl.acc_op)
      ACC_HOLD: acc <= acc;
      ACC_LOAD: acc <= prod[SUM_W-1:0];
      ACC_ADD:  acc <= acc + prod[SUM_W-1:0];
      default:  acc <= acc;
    endcase
    if (ctl.scale_en) begin
      level <= scaled[PROD_W-1:PROD_SHIFT];
    end
    if (ctl.div_init) begin
      clip    <= clip_pos | clip_neg;
      mixed   <= clip_pos ? SAMPLE_MAX : clip_neg ? SAMPLE_MIN : level[SAMPLE_W-1:0];
      divisor <= clip_pos ? level : -level;
      rem     <= {{(SCALED_W-(NUM_W-QUO_W)){1'b0}}, numer[NUM_W-1:QUO_W]};
      dq      <= numer[QUO_W-1:0];
      div_cnt <= 4'(QUO_W);
    end else if (ctl.div_step) begin
      rem     <= fits ? diff[SCALED_W-1:0] : trial[SCALED_W-1:0];
      dq      <= {dq[QUO_W-2:0], fits};
      div_cnt <= div_cnt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attenuation <= UNITY_Q15;
    end else if (ctl.att_load) begin
      attenuation <= {1'b0, dq};
    end else if (ctl.recover && attenuation < UNITY_Q15) begin
      attenuation <= attenuation + (headroom >> RECOVERY_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data.mixed_sample <= mixed;
      out_data.clipped      <= clip;
      out_data.out_last     <= last;
    end
  end

`ifndef NO_ASSERTIONS
  a_att_unity: assert property (@(posedge clk) disable iff (rst)
    attenuation <= UNITY_Q15)
    else $error("attenuation above unity");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    ctl.div_step |-> (rem < divisor))
    else $error("divider remainder not below divisor");

  a_clip_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.clipped) |->
      (out_data.mixed_sample == SAMPLE_MAX || out_data.mixed_sample == SAMPLE_MIN))
    else $error("clipped item not saturated");

  a_clip_factor: assert property (@(posedge clk) disable iff (rst)
    ctl.att_load |=> attenuation < UNITY_Q15)
    else $error("factor reset did not drop below unity");
`endif

endmodule

/* rtl/core/adaptive_gain_pcm_mixer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_gain_pcm_mixer
// Two-input PCM mixer with gains, adaptive attenuation and clip limiter.
// ----------------------------------------------------------------------------
// An item goes from acceptance to the result register through the multiply,
// add, scale, check, recovery and emit steps; when the output clips, the
// radix-2 divider steps run between check and recovery to compute the new
// 15-bit attenuation factor. All steps come from a small microcode program
// driving one shared 34x17 multiplier; one item is in work at a time, and
// the next is accepted only after the previous result has been loaded into
// the output register, by way of the wrap and idle steps. A result still
// held by the receiver stalls the program at the load step. Gain registers
// (index 0 music, index 1 vocal, Q4.12) are written through the cfg channel,
// which is always ready; write them only while idle.
module adaptive_gain_pcm_mixer (
  input  logic        clk,
  input  logic        rst,
  agpm_chan_if.sink   sample,
  agpm_chan_if.source result,
  agpm_chan_if.sink   cfg
);
  import agpm_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  agpm_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  agpm_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .stat   (stat),
    .sample (sample),
    .result (result),
    .cfg    (cfg)
  );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the adaptive-gain PCM mixer. A queue-fed driver
// offers sample items and a clocked monitor compares each result with a
// cycle-free model of the gain, attenuation, clamp and recovery arithmetic.
// Gains are changed between phases while the mixer is idle.
// ----------------------------------------------------------------------------
module testbench;
  import agpm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 150;

  logic clk;
  logic rst;

  agpm_chan_if #(.T(sample_t))    sample_if ();
  agpm_chan_if #(.T(result_t))    result_if ();
  agpm_chan_if #(.T(cfg_write_t)) cfg_if ();

  adaptive_gain_pcm_mixer uut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  // model state
  logic [GAIN_W-1:0] gain_music;
  logic [GAIN_W-1:0] gain_vocal;
  longint            atten_q15;

  sample_t    pending_samples[$];
  result_t    expected_mix[$];
  cfg_write_t cfg_batch[$];
  result_t    mix_want;

  bit quiet = 1'b0;
  int accepted_cnt;
  int error_cnt;
  int cycle_cnt;
  int gap_left;
  int stall_left;
  int hold_left;
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic result_t mix_predict(input sample_t s);
    longint  mix_sum;
    longint  scaled;
    result_t r;
    mix_sum = longint'($signed(s.music_sample)) * longint'(gain_music)
            + longint'($signed(s.vocal_sample)) * longint'(gain_vocal);
    // signed division truncates toward zero
    scaled = (mix_sum * atten_q15) / (longint'(1) << PROD_SHIFT);
    r.clipped  = 1'b0;
    r.out_last = s.in_last;
    if (scaled > longint'(SAMPLE_MAX)) begin
      atten_q15      = (longint'(32767) * 32768) / scaled;
      r.mixed_sample = SAMPLE_MAX;
      r.clipped      = 1'b1;
    end else if (scaled < longint'(SAMPLE_MIN)) begin
      atten_q15      = (longint'(32768) * 32768) / (-scaled);
      r.mixed_sample = SAMPLE_MIN;
      r.clipped      = 1'b1;
    end else begin
      r.mixed_sample = scaled[15:0];
    end
    // recovery follows any reset in the same item
    if (atten_q15 < longint'(UNITY_Q15))
      atten_q15 = atten_q15 + ((longint'(UNITY_Q15) - atten_q15) >>> RECOVERY_SHIFT);
    atten_q15 = atten_q15 & 64'hFFFF;
    return r;
  endfunction

  function automatic logic signed [15:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return 16'sd0;
      default: return -16'sd1;
    endcase
  endfunction

  task automatic queue_sample(input int vocal, input int music, input bit last);
    sample_t s;
    s.vocal_sample = vocal[15:0];
    s.music_sample = music[15:0];
    s.in_last      = last;
    pending_samples.push_back(s);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_samples.size() != 0 || sample_if.valid || expected_mix.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_regs();
    cfg_write_t w;
    while (cfg_batch.size() != 0) begin
      w = cfg_batch.pop_front();
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= w;
      do @(posedge clk); while (!cfg_if.ready);
      if (w.reg_index == REG_MUSIC_GAIN)
        gain_music = w.wdata;
      else if (w.reg_index == REG_VOCAL_GAIN)
        gain_vocal = w.wdata;
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] music, input logic [GAIN_W-1:0] vocal,
                           input logic [REG_IDX_W-1:0] junk_idx);
    cfg_batch.push_back(cfg_write_t'{reg_index: REG_MUSIC_GAIN, wdata: music});
    // out-of-range index, must leave both gains alone
    cfg_batch.push_back(cfg_write_t'{reg_index: junk_idx, wdata: 16'($urandom)});
    cfg_batch.push_back(cfg_write_t'{reg_index: REG_VOCAL_GAIN, wdata: vocal});
    write_regs();
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      sample_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (sample_if.valid && sample_if.ready) begin
        expected_mix.push_back(mix_predict(sample_if.data));
        accepted_cnt <= accepted_cnt + 1;
        if (!quiet && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 4);
      end
      if (!sample_if.valid || sample_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          sample_if.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          sample_if.valid <= 1'b1;
          sample_if.data  <= pending_samples.pop_front();
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off, once, so the mixer backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expected_mix.size() == 0) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("unexpected item: mixed=%0d clipped=%0b last=%0b",
                     result_if.data.mixed_sample, result_if.data.clipped,
                     result_if.data.out_last);
        end else begin
          mix_want = expected_mix.pop_front();
          if (result_if.data.mixed_sample !== mix_want.mixed_sample ||
              result_if.data.clipped !== mix_want.clipped ||
              result_if.data.out_last !== mix_want.out_last) begin
            error_cnt++;
            if (error_cnt <= 10)
              $display("mismatch: expected mixed=%0d clipped=%0b last=%0b, got %0d %0b %0b",
                       mix_want.mixed_sample, mix_want.clipped, mix_want.out_last,
                       result_if.data.mixed_sample, result_if.data.clipped,
                       result_if.data.out_last);
          end
        end
      end
      if (hold_left != 0) begin
        result_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    sample_t s;
    int      kind;
    rst             = 1'b1;
    sample_if.valid = 1'b0;
    sample_if.data  = '0;
    result_if.ready = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    gain_music      = GAIN_RESET;
    gain_vocal      = GAIN_RESET;
    atten_q15       = longint'(UNITY_Q15);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset gains: zero, full-scale clips both ways, recovery afterwards
    queue_sample(0, 0, 1'b0);
    queue_sample(32767, 32767, 1'b0);
    queue_sample(1000, -1000, 1'b1);
    queue_sample(16000, 10000, 1'b0);
    queue_sample(-32768, -32768, 1'b0);
    queue_sample(-32768, 32767, 1'b0);
    queue_sample(32767, -32768, 1'b1);
    queue_sample(-1, -1, 1'b0);
    queue_sample(12345, -4321, 1'b0);
    queue_sample(-20000, -20000, 1'b1);
    queue_sample(20000, 20000, 1'b0);

    // top gains
    wait_idle();
    set_gains(16'hFFFF, 16'hFFFF, 4'd15);
    queue_sample(32767, 32767, 1'b0);
    queue_sample(-32768, -32768, 1'b1);
    queue_sample(1, 0, 1'b0);
    queue_sample(0, -1, 1'b0);

    // zero gains: silence while the factor recovers
    wait_idle();
    set_gains(16'h0000, 16'h0000, 4'd2);
    queue_sample(32767, -32768, 1'b0);
    queue_sample(-32768, 32767, 1'b1);
    queue_sample(100, 100, 1'b0);

    wait_idle();
    set_gains(16'd4096, 16'd2048, 4'd8);
    queue_sample(32767, 32767, 1'b0);
    queue_sample(-32768, 0, 1'b0);
    queue_sample(-300, 700, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      quiet <= (ph == 3 || ph == 5);
      case (ph)
        0: set_gains(GAIN_RESET, GAIN_RESET, 4'($urandom_range(2, 15)));
        1: set_gains(16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191)),
                     4'($urandom_range(2, 15)));
        2: set_gains(16'($urandom), 16'($urandom), 4'($urandom_range(2, 15)));
        3: set_gains(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024)),
                     4'($urandom_range(2, 15)));
        4: set_gains(16'($urandom_range(2048, 6000)), 16'($urandom_range(2048, 6000)),
                     4'($urandom_range(2, 15)));
        default: set_gains(16'hFFFF, 16'h0000, 4'($urandom_range(2, 15)));
      endcase
      for (int n = 0; n < 75; n++) begin
        kind = $urandom_range(0, 7);
        case (kind)
          0, 1, 2, 3: begin
            s.vocal_sample = 16'($urandom);
            s.music_sample = 16'($urandom);
          end
          4, 5: begin
            s.vocal_sample = 16'($urandom_range(0, 4095) - 2048);
            s.music_sample = 16'($urandom_range(0, 4095) - 2048);
          end
          6: begin
            s.vocal_sample = pick_extreme();
            s.music_sample = pick_extreme();
          end
          default: begin
            // same-sign loud pair, likely to clip
            s.vocal_sample = 16'($urandom);
            s.music_sample = s.vocal_sample;
          end
        endcase
        s.in_last = ($urandom_range(0, 7) == 0);
        pending_samples.push_back(s);
      end
    end

    wait_idle();
    if (error_cnt == 0 && expected_mix.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
